@@ sv/assert_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that requires another in the following cycle.
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `PSE_ASSERT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

@@ sv/pse_pkg.sv @@
package pse_pkg;

  // CRC-32 as used by PNG chunks.
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Adler-32 modulus.
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // File signature and chunk type codes.
  localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;
  // CRC of an empty IEND chunk is fixed.
  localparam logic [31:0] IEND_CRC  = 32'hAE426082;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Depth of the queue between front and back.
  localparam int unsigned Q_DEPTH = 2;

  // Classification of one pixel, made by the front.
  typedef struct packed {
    logic sof;
    logic row_start;
    logic eof;
  } pse_flags_t;

  // One byte of the reflected CRC-32 update.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Big-endian byte of a word; sel 0 is the most significant byte.
  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [1:0] s;
    s = 2'd3 - sel;
    return w[8*s +: 8];
  endfunction

endpackage

@@ sv/png_stored_deflate_encoder_top.sv @@
// PNG encoder with stored deflate blocks.
// Input channel: BGR pixels in raster order; a beat is taken when push is high
// and full is low. Output channel: PNG file bytes; the oldest byte is shown while
// empty is low and taken when pop is high. run_last_o marks the last byte caused
// by a pixel, file_last_o the last byte of the file.
// Configuration: cfg_we_i writes image width (index 0) or height (index 1);
// new sizes apply from the next frame. Write only while the block is idle.
// Throughput: one output byte per cycle while pop stays high; a pixel gives 3
// bytes, 4 at a row start, plus 5 for each stored block header. The first pixel
// of a frame adds the 43-byte header; its IDAT length comes from a block count
// reciprocal multiply that the back starts on taking the pixel, done long before
// the header reaches its length field. The last pixel adds a 20-byte trailer. A
// pixel's beat passes the queue and the current-item registers before its first
// byte is registered for output. A two-entry queue separates the pixel front from
// the byte back, so pixels are taken while a byte waits. When pop stays low the
// output byte holds and the queue fills, then full rises. Reset sets all state but
// the queue storage; the sizes return to 640 by 480 and no frame is open.
module png_stored_deflate_encoder_top #(
  parameter int unsigned DIM_BITS         = 14,
  parameter int unsigned STORED_BLOCK_MAX = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                file_last_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [DIM_BITS-1:0] cfg_data_i
);
  import pse_pkg::*;

  localparam int unsigned EW = $bits(pse_flags_t) + 2 * DIM_BITS + 24;

  logic                wr, q_full, q_valid, q_pop;
  pse_flags_t          f_flags, b_flags;
  logic [DIM_BITS-1:0] f_w, f_h, b_w, b_h;
  logic [7:0]          b_r, b_g, b_b;
  logic [EW-1:0]       wdata, rdata;

  assign full  = q_full;
  assign wdata = {f_flags, f_w, f_h, red_i, green_i, blue_i};
  assign {b_flags, b_w, b_h, b_r, b_g, b_b} = rdata;

  // Pixel classification.
  pse_front #(.DIM_BITS(DIM_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (q_full),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .wr_o       (wr),
    .flags_o    (f_flags),
    .width_o    (f_w),
    .height_o   (f_h)
  );

  // Pixel queue between front and back.
  pse_queue #(.WIDTH(EW), .DEPTH(Q_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wdata),
    .full_o  (q_full),
    .rd_i    (q_pop),
    .valid_o (q_valid),
    .rdata_o (rdata)
  );

  // Byte stream generation.
  pse_back #(.DIM_BITS(DIM_BITS), .STORED_BLOCK_MAX(STORED_BLOCK_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .flags_i     (b_flags),
    .width_i     (b_w),
    .height_i    (b_h),
    .red_i       (b_r),
    .green_i     (b_g),
    .blue_i      (b_b),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .file_last_o (file_last_o)
  );
endmodule

@@ sv/pse_queue.sv @@
module pse_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [IW-1:0]    wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rp_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  // Storage, written at the write pointer.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == IW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == IW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end
endmodule

@@ sv/pse_front.sv @@
module pse_front #(
  parameter int unsigned DIM_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [DIM_BITS-1:0] cfg_data_i,
  output logic                wr_o,
  output pse_pkg::pse_flags_t flags_o,
  output logic [DIM_BITS-1:0] width_o,
  output logic [DIM_BITS-1:0] height_o
);
  import pse_pkg::*;

  logic [DIM_BITS-1:0] width_q, height_q;
  logic [DIM_BITS-1:0] aw_q, ah_q, col_q, row_q;
  logic                open_q;
  logic [DIM_BITS-1:0] w_use, h_use, cur_w, cur_h;
  logic                last_col, accept;

  // Sizes in use: clamp to the legal minimum, frozen while a frame is open.
  assign w_use  = (width_q < DIM_BITS'(2)) ? DIM_BITS'(2) : width_q;
  assign h_use  = (height_q == '0) ? DIM_BITS'(1) : height_q;
  assign cur_w  = open_q ? aw_q : w_use;
  assign cur_h  = open_q ? ah_q : h_use;

  // Classify the pixel by its raster position.
  assign accept            = push_i && !full_i;
  assign last_col          = (col_q == cur_w - 1'b1);
  assign flags_o.sof       = !open_q;
  assign flags_o.row_start = (col_q == '0);
  assign flags_o.eof       = last_col && (row_q == cur_h - 1'b1);
  assign wr_o              = accept;
  assign width_o           = cur_w;
  assign height_o          = cur_h;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_BITS'(640);
      height_q <= DIM_BITS'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Frame position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      aw_q   <= '0;
      ah_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else if (accept) begin
      if (!open_q) begin
        aw_q <= w_use;
        ah_q <= h_use;
      end
      if (flags_o.eof) begin
        open_q <= 1'b0;
        col_q  <= '0;
        row_q  <= '0;
      end else begin
        open_q <= 1'b1;
        if (last_col) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/pse_back.sv @@
module pse_back #(
  parameter int unsigned DIM_BITS         = 14,
  parameter int unsigned STORED_BLOCK_MAX = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  pse_pkg::pse_flags_t flags_i,
  input  logic [DIM_BITS-1:0] width_i,
  input  logic [DIM_BITS-1:0] height_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o,
  output logic                file_last_o
);
  import pse_pkg::*;

  localparam int unsigned RAW_BITS = 2 * DIM_BITS + 2;
  localparam int unsigned DVW      = RAW_BITS + 1;
  localparam int unsigned MAXW     = $clog2(STORED_BLOCK_MAX + 1);
  localparam int unsigned RSH      = DVW + $clog2(STORED_BLOCK_MAX);
  localparam int unsigned NCH      = (DVW + 16) / 16;
  localparam int unsigned RCW      = 16 * NCH;
  localparam int unsigned PPW      = DVW + 16;
  localparam int unsigned AW       = DVW + RCW;
  localparam int unsigned CNTW     = $clog2(NCH + 1);
  localparam int unsigned IDW      = RAW_BITS + 36;
  localparam int unsigned CMPW     = RAW_BITS + 17;
  localparam logic [MAXW-1:0] BLK_MAX = MAXW'(STORED_BLOCK_MAX);
  // Reciprocal of the block size, rounded up and scaled by 2**RSH.
  localparam logic [RSH:0] RCP_WIDE =
    (((RSH+1)'(1) << RSH) + (RSH+1)'(STORED_BLOCK_MAX - 1)) / (RSH+1)'(STORED_BLOCK_MAX);
  localparam logic [RCW-1:0] RCP = RCW'(RCP_WIDE);

  // Byte positions inside the frame header and trailer.
  localparam logic [5:0] HDR_IDAT_LEN = 6'd33;
  localparam logic [5:0] HDR_LAST     = 6'd42;
  localparam logic [5:0] BLK_LAST     = 6'd4;
  localparam logic [5:0] TRL_LAST     = 6'd19;

  typedef enum logic [1:0] {PH_HDR, PH_RAW, PH_TRL} ph_e;
  typedef enum logic [2:0] {DV_IDLE, DV_LOAD, DV_RUN, DV_FIN, DV_DONE} dv_e;

  ph_e                 ph_q;
  dv_e                 dv_q;
  logic                cur_v_q;
  pse_flags_t          cfl_q;
  logic [DIM_BITS-1:0] cw_q, ch_q;
  logic [7:0]          cr_q, cg_q, cb_q;
  logic [5:0]          idx_q;
  logic [1:0]          rsel_q;
  logic [31:0]         crc_q;
  logic [15:0]         lo_q, hi_q;
  logic [RAW_BITS-1:0] raw_q, raw_left_q;
  logic [MAXW-1:0]     blk_left_q;
  logic [DVW-1:0]      dvd_q;
  logic [AW-1:0]       acc_q;
  logic [RCW-1:0]      rcp_q;
  logic [CNTW-1:0]     cnt_q;
  logic [31:0]         idat_q;
  logic                ov_q, orl_q, ofl_q;
  logic [7:0]          ob_q;

  logic                out_free, hdr_wait, emit, crc_use, item_end, file_end, done;
  logic [31:0]         crc_seed, w32, h32;
  logic [7:0]          ebyte, rbyte;
  logic [MAXW-1:0]     blk;
  logic [15:0]         blk16;
  logic                final_blk;
  logic [16:0]         lo_sum, hi_sum;
  logic [15:0]         lo_n, hi_n;
  logic [DIM_BITS+1:0] w3;
  logic [RAW_BITS-1:0] prod;
  logic [PPW-1:0]      pp;
  logic [AW-1:0]       quo;
  logic [IDW-1:0]      idat_full;

  assign w32 = 32'(cw_q);
  assign h32 = 32'(ch_q);

  // Raw data length of a frame: (3 * width + 1) * height.
  assign w3   = (DIM_BITS+2)'({width_i, 1'b0}) + (DIM_BITS+2)'(width_i) + (DIM_BITS+2)'(1);
  assign prod = RAW_BITS'(w3) * RAW_BITS'(height_i);

  // One 16-bit slice of the block count reciprocal multiply, top slice first.
  assign pp        = PPW'(dvd_q) * PPW'(rcp_q[RCW-1 -: 16]);
  assign quo       = acc_q >> RSH;
  assign idat_full = IDW'(6) + IDW'(raw_q) + IDW'(quo) + (IDW'(quo) << 2);

  // Size of the next stored block.
  assign blk = (CMPW'(raw_left_q) < CMPW'(STORED_BLOCK_MAX)) ? MAXW'(raw_left_q) : BLK_MAX;
  assign blk16     = 16'(blk);
  assign final_blk = (CMPW'(blk) == CMPW'(raw_left_q));

  // Raw byte and Adler sums.
  always_comb begin
    case (rsel_q)
      2'd0:    rbyte = 8'h00;
      2'd1:    rbyte = cr_q;
      2'd2:    rbyte = cg_q;
      default: rbyte = cb_q;
    endcase
    lo_sum = {1'b0, lo_q} + 17'(rbyte);
    lo_n   = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, hi_q} + {1'b0, lo_n};
    hi_n   = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  // Byte selection for the current phase.
  assign out_free = !ov_q || pop_i;
  assign hdr_wait = (ph_q == PH_HDR) && (idx_q >= HDR_IDAT_LEN) && (dv_q != DV_DONE);
  assign emit     = cur_v_q && out_free && !hdr_wait;

  always_comb begin
    ebyte    = 8'h00;
    crc_use  = 1'b0;
    crc_seed = crc_q;
    item_end = 1'b0;
    file_end = 1'b0;
    case (ph_q)
      PH_HDR: begin
        if (idx_q < 6'd8) begin
          ebyte = PNG_SIG[8*(3'd7 - idx_q[2:0]) +: 8];
        end else if (idx_q < 6'd12) begin
          ebyte = (idx_q == 6'd11) ? 8'd13 : 8'd0;
        end else if (idx_q < 6'd16) begin
          ebyte = word_byte(TYPE_IHDR, idx_q[1:0]);
        end else if (idx_q < 6'd20) begin
          ebyte = word_byte(w32, idx_q[1:0]);
        end else if (idx_q < 6'd24) begin
          ebyte = word_byte(h32, idx_q[1:0]);
        end else if (idx_q == 6'd24) begin
          ebyte = 8'd8;
        end else if (idx_q == 6'd25) begin
          ebyte = 8'd2;
        end else if (idx_q < 6'd29) begin
          ebyte = 8'd0;
        end else if (idx_q < 6'd33) begin
          ebyte = word_byte(~crc_q, idx_q[1:0] - 2'd1);
        end else if (idx_q < 6'd37) begin
          ebyte = word_byte(idat_q, idx_q[1:0] - 2'd1);
        end else if (idx_q < 6'd41) begin
          ebyte = word_byte(TYPE_IDAT, idx_q[1:0] - 2'd1);
        end else if (idx_q == 6'd41) begin
          ebyte = 8'h78;
        end else begin
          ebyte = 8'h01;
        end
        crc_use = ((idx_q >= 6'd12) && (idx_q < 6'd29)) || (idx_q >= 6'd37);
        if ((idx_q == 6'd12) || (idx_q == 6'd37)) begin
          crc_seed = CRC_INIT;
        end
      end
      PH_RAW: begin
        crc_use = 1'b1;
        if (blk_left_q == '0) begin
          case (idx_q[2:0])
            3'd0:    ebyte = {7'd0, final_blk};
            3'd1:    ebyte = blk16[7:0];
            3'd2:    ebyte = blk16[15:8];
            3'd3:    ebyte = ~blk16[7:0];
            default: ebyte = ~blk16[15:8];
          endcase
        end else begin
          ebyte    = rbyte;
          item_end = (rsel_q == 2'd3) && !cfl_q.eof;
        end
      end
      PH_TRL: begin
        if (idx_q < 6'd4) begin
          ebyte   = word_byte({hi_q, lo_q}, idx_q[1:0]);
          crc_use = 1'b1;
        end else if (idx_q < 6'd8) begin
          ebyte = word_byte(~crc_q, idx_q[1:0]);
        end else if (idx_q < 6'd12) begin
          ebyte = 8'd0;
        end else if (idx_q < 6'd16) begin
          ebyte = word_byte(TYPE_IEND, idx_q[1:0]);
        end else begin
          ebyte = word_byte(IEND_CRC, idx_q[1:0]);
        end
        file_end = (idx_q == TRL_LAST);
        item_end = file_end;
      end
      default: ;
    endcase
  end

  assign done     = emit && item_end;
  assign q_pop_o  = q_valid_i && (!cur_v_q || done);

  assign empty_o     = !ov_q;
  assign out_byte_o  = ob_q;
  assign run_last_o  = orl_q;
  assign file_last_o = ofl_q;

  // Block count by reciprocal multiply, started by each frame's first pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q   <= DV_IDLE;
      raw_q  <= '0;
      dvd_q  <= '0;
      acc_q  <= '0;
      rcp_q  <= '0;
      cnt_q  <= '0;
      idat_q <= '0;
    end else begin
      case (dv_q)
        DV_LOAD: begin
          dvd_q <= DVW'(raw_q) + DVW'(STORED_BLOCK_MAX - 1);
          acc_q <= '0;
          rcp_q <= RCP;
          cnt_q <= CNTW'(NCH);
          dv_q  <= DV_RUN;
        end
        DV_RUN: begin
          acc_q <= (acc_q << 16) + AW'(pp);
          rcp_q <= rcp_q << 16;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) begin
            dv_q <= DV_FIN;
          end
        end
        DV_FIN: begin
          idat_q <= idat_full[31:0];
          dv_q   <= DV_DONE;
        end
        default: ;
      endcase
      if (q_pop_o && flags_i.sof) begin
        raw_q <= prod;
        dv_q  <= DV_LOAD;
      end
    end
  end

  // Byte sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_HDR;
      cur_v_q    <= 1'b0;
      cfl_q      <= '0;
      cw_q       <= '0;
      ch_q       <= '0;
      cr_q       <= '0;
      cg_q       <= '0;
      cb_q       <= '0;
      idx_q      <= '0;
      rsel_q     <= '0;
      crc_q      <= CRC_INIT;
      lo_q       <= 16'd1;
      hi_q       <= '0;
      raw_left_q <= '0;
      blk_left_q <= '0;
      ov_q       <= 1'b0;
      ob_q       <= '0;
      orl_q      <= 1'b0;
      ofl_q      <= 1'b0;
    end else begin
      if (emit) begin
        ov_q  <= 1'b1;
        ob_q  <= ebyte;
        orl_q <= item_end;
        ofl_q <= file_end;
        if (crc_use) begin
          crc_q <= crc_byte(crc_seed, ebyte);
        end
        case (ph_q)
          PH_HDR: begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == HDR_LAST) begin
              ph_q       <= PH_RAW;
              idx_q      <= '0;
              raw_left_q <= raw_q;
              blk_left_q <= '0;
              lo_q       <= 16'd1;
              hi_q       <= '0;
            end
          end
          PH_RAW: begin
            if (blk_left_q == '0) begin
              if (idx_q == BLK_LAST) begin
                idx_q      <= '0;
                blk_left_q <= blk;
              end else begin
                idx_q <= idx_q + 1'b1;
              end
            end else begin
              lo_q       <= lo_n;
              hi_q       <= hi_n;
              blk_left_q <= blk_left_q - 1'b1;
              raw_left_q <= raw_left_q - 1'b1;
              rsel_q     <= rsel_q + 1'b1;
              if ((rsel_q == 2'd3) && cfl_q.eof) begin
                ph_q  <= PH_TRL;
                idx_q <= '0;
              end
            end
          end
          PH_TRL: idx_q <= idx_q + 1'b1;
          default: ;
        endcase
      end else if (pop_i && ov_q) begin
        ov_q <= 1'b0;
      end

      // Next item from the queue, or go idle.
      if (q_pop_o) begin
        cur_v_q <= 1'b1;
        cfl_q   <= flags_i;
        cw_q    <= width_i;
        ch_q    <= height_i;
        cr_q    <= red_i;
        cg_q    <= green_i;
        cb_q    <= blue_i;
        ph_q    <= flags_i.sof ? PH_HDR : PH_RAW;
        idx_q   <= '0;
        rsel_q  <= flags_i.row_start ? 2'd0 : 2'd1;
      end else if (done) begin
        cur_v_q <= 1'b0;
      end
    end
  end
endmodule

@@ sv/pse_checker.sv @@
`include "assert_macros.svh"

module pse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       file_last_o
);
  logic shown, stall, file_end;

  // A byte is shown, a shown byte is held, a shown byte ends the file.
  assign shown    = !empty;
  assign stall    = !empty && !pop;
  assign file_end = !empty && file_last_o;

  // The end of the file also ends the last pixel's bytes.
  `PSE_ASSERT(a_file_ends_run, clk_i, rst_ni, file_end |-> run_last_o, "file end without run end")
  // The last file byte is the final byte of the IEND CRC.
  `PSE_ASSERT(a_file_end_byte, clk_i, rst_ni, file_end |-> (out_byte_o == 8'h82), "bad last byte")
  // A waiting beat holds its byte.
  `PSE_ASSERT_NEXT(a_hold_byte, clk_i, rst_ni, stall, shown && $stable(out_byte_o), "byte moved")
  // A waiting beat holds its markers.
  `PSE_ASSERT_NEXT(a_hold_run, clk_i, rst_ni, stall, $stable(run_last_o), "run mark moved")
  `PSE_ASSERT_NEXT(a_hold_file, clk_i, rst_ni, stall, $stable(file_last_o), "file mark moved")
endmodule

bind png_stored_deflate_encoder_top pse_checker u_checker (.*);

@@ test/testbench.sv @@
module testbench;
  import pse_pkg::*;

  localparam int unsigned DimBits  = 14;
  localparam int unsigned AdlerMod = 65521;
  localparam int unsigned BlockMax = 65535;

  // One byte of the PNG stream with its markers.
  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       file_last;
  } png_beat_t;

  // Predicts the PNG byte stream from accepted pixels and checks the output.
  class png_scoreboard;
    logic [DimBits-1:0] reg_width  = 640;
    logic [DimBits-1:0] reg_height = 480;
    int unsigned     frame_width, frame_height, column;
    longint unsigned raw_left;
    int unsigned     block_left, adler_lo, adler_hi;
    logic [31:0]     crc;
    bit              frame_open;
    png_beat_t       pending[$];
    int unsigned     errors, bytes_checked, frames_done;

    function new();
      crc = CRC_INIT;
      adler_lo = 1;
    endfunction

    function void note_config(logic idx, logic [DimBits-1:0] value);
      if (idx == REG_WIDTH) reg_width = value;
      else if (idx == REG_HEIGHT) reg_height = value;
    endfunction

    function void put_plain(logic [7:0] b);
      png_beat_t beat;
      beat.data = b;
      beat.run_last = 1'b0;
      beat.file_last = 1'b0;
      pending.push_back(beat);
    endfunction

    function void put_crc(logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      crc = c;
      put_plain(b);
    endfunction

    function void put_word(logic [31:0] v, bit with_crc);
      for (int s = 24; s >= 0; s -= 8) begin
        if (with_crc) put_crc(v[s +: 8]);
        else put_plain(v[s +: 8]);
      end
    endfunction

    function void chunk_begin(logic [31:0] len, logic [31:0] kind);
      put_word(len, 1'b0);
      crc = CRC_INIT;
      put_word(kind, 1'b1);
    endfunction

    function void chunk_end();
      put_word(crc ^ CRC_INIT, 1'b0);
    endfunction

    // Raw image byte, opening a stored block when the previous one is full.
    function void put_raw(logic [7:0] b);
      int unsigned blk;
      logic [15:0] inv;
      if (raw_left == 0) return;
      if (block_left == 0) begin
        blk = (raw_left < BlockMax) ? int'(raw_left) : BlockMax;
        inv = ~blk[15:0];
        put_crc((blk == raw_left) ? 8'd1 : 8'd0);
        put_crc(blk[7:0]);
        put_crc(blk[15:8]);
        put_crc(inv[7:0]);
        put_crc(inv[15:8]);
        block_left = blk;
      end
      adler_lo = (adler_lo + b) % AdlerMod;
      adler_hi = (adler_hi + adler_lo) % AdlerMod;
      put_crc(b);
      block_left--;
      raw_left--;
    endfunction

    function void start_frame();
      longint unsigned raw, blocks, idat_len;
      frame_width  = (reg_width < 2) ? 2 : reg_width;
      frame_height = (reg_height < 1) ? 1 : reg_height;
      raw = (longint'(frame_width) * 3 + 1) * frame_height;
      blocks = (raw + BlockMax - 1) / BlockMax;
      idat_len = 2 + blocks * 5 + raw + 4;
      for (int i = 7; i >= 0; i--) put_plain(PNG_SIG[8*i +: 8]);
      chunk_begin(32'd13, TYPE_IHDR);
      put_word(frame_width, 1'b1);
      put_word(frame_height, 1'b1);
      put_crc(8'd8);
      put_crc(8'd2);
      put_crc(8'd0);
      put_crc(8'd0);
      put_crc(8'd0);
      chunk_end();
      chunk_begin(idat_len[31:0], TYPE_IDAT);
      put_crc(8'h78);
      put_crc(8'h01);
      raw_left = raw;
      block_left = 0;
      adler_lo = 1;
      adler_hi = 0;
      column = 0;
      frame_open = 1'b1;
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      if (!frame_open) start_frame();
      if (column == 0) put_raw(8'd0);
      put_raw(r);
      put_raw(g);
      put_raw(b);
      column = (column + 1) % (1 << DimBits);
      if (column >= frame_width) column = 0;
      if (raw_left == 0) begin
        put_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
        chunk_end();
        chunk_begin(32'd0, TYPE_IEND);
        chunk_end();
        pending[pending.size()-1].file_last = 1'b1;
        frame_open = 1'b0;
        column = 0;
        frames_done++;
      end
      pending[pending.size()-1].run_last = 1'b1;
    endfunction

    function void check_byte(logic [7:0] data, logic run_last, logic file_last);
      png_beat_t want;
      if (pending.size() == 0) begin
        $error("unexpected output byte %h", data);
        errors++;
        return;
      end
      want = pending.pop_front();
      bytes_checked++;
      if (data !== want.data) begin
        $error("out_byte: expected %h, got %h", want.data, data);
        errors++;
      end
      if (run_last !== want.run_last) begin
        $error("run_last: expected %b, got %b", want.run_last, run_last);
        errors++;
      end
      if (file_last !== want.file_last) begin
        $error("file_last: expected %b, got %b", want.file_last, file_last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [7:0]         blue_i = '0, green_i = '0, red_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         out_byte_o;
  logic               run_last_o, file_last_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [DimBits-1:0] cfg_data_i = '0;

  png_scoreboard sb = new();
  int unsigned   burst_left = 0;
  int unsigned   pixels_sent = 0;
  int unsigned   random_pixels = 0;
  int unsigned   stall_cycle = 0;
  int unsigned   stall_mode = 0;

  png_stored_deflate_encoder_top dut (
    .clk_i, .rst_ni, .push, .full, .blue_i, .green_i, .red_i,
    .empty, .pop, .out_byte_o, .run_last_o, .file_last_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Receiver: check each accepted byte; stall in phases of differing density.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_byte(out_byte_o, run_last_o, file_last_o);
    stall_cycle++;
    if (stall_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 9) < 7);
      2: pop <= ($urandom_range(0, 9) < 2);
      default: pop <= ((stall_cycle % 13) > 4);
    endcase
  end

  // One register write; the write port then idles before the task returns.
  task automatic write_reg(logic idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[DimBits-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.note_config(idx, value[DimBits-1:0]);
    @(posedge clk_i);
  endtask

  // Offer one pixel and hold it until the beat is taken, then maybe pause.
  task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned gap;
    blue_i  <= b;
    green_i <= g;
    red_i   <= r;
    push    <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.note_pixel(b, g, r);
    pixels_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // One whole frame; the first few pixels of a directed frame use edge values.
  task automatic run_frame(int unsigned w, int unsigned h, bit directed);
    int unsigned n, eff_w, eff_h;
    logic [7:0] v;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    eff_w = (w < 2) ? 2 : w;
    eff_h = (h < 1) ? 1 : h;
    n = eff_w * eff_h;
    for (int i = 0; i < n; i++) begin
      if (directed && i < 8) begin
        case (i % 4)
          0: v = 8'h00;
          1: v = 8'hFF;
          2: v = 8'hAA;
          default: v = 8'h55;
        endcase
        send_pixel(v, ~v, v ^ 8'h0F);
      end else begin
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
        if (!directed) random_pixels++;
      end
    end
    push <= 1'b0;
    wait_drained();
  endtask

  // Main sequence: directed small and below-range sizes, then random small frames.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_frame(2, 1, 1'b1);
    run_frame(0, 0, 1'b1);
    run_frame(1, 3, 1'b1);
    run_frame(3, 2, 1'b1);
    while (pixels_sent < 170) begin
      if ($urandom_range(0, 9) == 0) run_frame($urandom_range(0, 1), $urandom_range(0, 4), 1'b0);
      else run_frame($urandom_range(2, 9), $urandom_range(1, 4), 1'b0);
    end
    $display("Covered %0d frames from %0d pixels (%0d random), %0d bytes checked.",
             sb.frames_done, pixels_sent, random_pixels, sb.bytes_checked);
    $display("Small and below-range frame sizes, bursty input and a stalling receiver.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #80000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+sv
sv/pse_pkg.sv
sv/pse_queue.sv
sv/pse_front.sv
sv/pse_back.sv
sv/png_stored_deflate_encoder_top.sv
sv/pse_checker.sv
test/testbench.sv
